// ===== src/outbound_inflight_id_table_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the outbound in-flight id table
// Immediate-implication and next-cycle-implication checks, clocked and reset.
// ---------------------------------------------------------------------------
`ifndef OUTBOUND_INFLIGHT_ID_TABLE_TOP_MACROS_SVH
`define OUTBOUND_INFLIGHT_ID_TABLE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define OIT_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("outbound_inflight_id_table: check failed");

`define OIT_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("outbound_inflight_id_table: check failed");

`else

`define OIT_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)

`define OIT_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

// ===== src/oit_pkg.sv =====
// ---------------------------------------------------------------------------
// oit_pkg
// Shared types and constants of the outbound in-flight id table.
// ---------------------------------------------------------------------------
`default_nettype none

package oit_pkg;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 64;
    localparam int CMD_W     = 3;
    localparam int ID_W      = 16;
    localparam int CNT_OUT_W = 5;

    localparam logic [1:0]      QOS_MAX  = 2'd2;
    localparam logic [ID_W-1:0] ID_FIRST = 16'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 3'd0,
        CMD_REMOVE   = 3'd1,
        CMD_LOOKUP   = 3'd2,
        CMD_ALLOC    = 3'd3,
        CMD_CLEAR    = 3'd4,
        CMD_RESET_ID = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_CLEAR,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [15:0]     message;
        logic [15:0]     topic;
        logic [1:0]      qos;
        logic            retain;
        logic            phase;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        cmd_t   cmd;
        entry_t ent;
    } req_t;

    typedef struct packed {
        logic                 ok;
        entry_t               ent;
        logic [CNT_OUT_W-1:0] count;
        logic                 full;
        logic                 last;
    } res_t;

    typedef struct packed {
        logic hit;
        logic free;
    } match_t;

endpackage

`default_nettype wire

// ===== src/oit_ram.sv =====
// ---------------------------------------------------------------------------
// oit_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module oit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/oit_match.sv =====
// ---------------------------------------------------------------------------
// oit_match
// Shared slot compare unit: id match against a key, and free-slot detect.
// ---------------------------------------------------------------------------
`default_nettype none

module oit_match (
    input  wire logic [oit_pkg::ID_W-1:0] key,
    input  wire logic [oit_pkg::ID_W-1:0] slot_id,
    input  wire logic                     slot_valid,
    output oit_pkg::match_t               res
);

    always_comb
    begin
        res.hit  = slot_valid && (slot_id == key);
        res.free = !slot_valid;
    end

endmodule

`default_nettype wire

// ===== src/oit_seq.sv =====
// ---------------------------------------------------------------------------
// oit_seq
// Command sequencer: sweeps the slot RAM through the compare unit, keeps the
// valid bits, count and rolling id, and holds the output item register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "outbound_inflight_id_table_top_macros.svh"

module oit_seq #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire oit_pkg::req_t                 in_req,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output oit_pkg::res_t                      out_res,
    output logic                               ram_we,
    output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_waddr,
    output logic [oit_pkg::ENTRY_W-1:0]        ram_wdata,
    output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_raddr,
    input  wire logic [oit_pkg::ENTRY_W-1:0]   ram_rdata
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    oit_pkg::state_t                state_reg, state_next;
    oit_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [oit_pkg::ID_W-1:0]       key_reg, key_next;
    oit_pkg::entry_t                in_ent_reg, in_ent_next;
    logic [oit_pkg::ID_W-1:0]       next_id_reg, next_id_next;
    logic [oit_pkg::ID_W-1:0]       cand_reg, cand_next;
    logic [CNT_W-1:0]               iss_cnt_reg, iss_cnt_next;
    logic                           pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]               pipe_idx_reg, pipe_idx_next;
    logic [TABLE_DEPTH-1:0]         valid_reg, valid_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic                           free_found_reg, free_found_next;
    logic [IDX_W-1:0]               free_idx_reg, free_idx_next;
    logic                           ok_reg, ok_next;
    oit_pkg::entry_t                ent_reg, ent_next;
    logic                           out_vld_reg, out_vld_next;
    oit_pkg::res_t                  out_reg, out_next;

    oit_pkg::entry_t                rd_ent;
    oit_pkg::entry_t                req_ent;
    oit_pkg::match_t                mt;
    logic [oit_pkg::ID_W-1:0]       cmp_key;
    logic [oit_pkg::ID_W-1:0]       nid_fix;
    logic [TABLE_DEPTH-1:0]         idx_onehot;
    logic                           in_fire;
    logic                           issue;
    logic                           full;
    logic                           out_free;
    logic                           pipe_last;
    logic                           rest_empty;
    logic                           scan_hit;
    logic                           scan_end;
    logic                           clr_hit;
    logic                           clr_done;
    logic                           load_out;
    oit_pkg::res_t                  load_val;

    assign rd_ent     = oit_pkg::entry_t'(ram_rdata);
    assign in_ready   = (state_reg == oit_pkg::ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign full       = (count_reg == CNT_W'(TABLE_DEPTH));
    assign out_free   = !out_vld_reg || out_ready;
    assign issue      = ((state_reg == oit_pkg::ST_SCAN) || (state_reg == oit_pkg::ST_CLEAR))
                        && (iss_cnt_reg != CNT_W'(TABLE_DEPTH));
    assign ram_raddr  = iss_cnt_reg[IDX_W-1:0];
    assign ram_we     = (state_reg == oit_pkg::ST_WRITE);
    assign ram_waddr  = free_idx_reg;
    assign ram_wdata  = in_ent_reg;
    assign cmp_key    = (cmd_reg == oit_pkg::CMD_ALLOC) ? cand_reg : key_reg;
    assign nid_fix    = (next_id_reg == '0) ? oit_pkg::ID_FIRST : next_id_reg;
    assign pipe_last  = (pipe_idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign idx_onehot = TABLE_DEPTH'(1'b1) << pipe_idx_reg;
    assign rest_empty = ((valid_reg & ~idx_onehot) == '0);
    assign scan_hit   = (state_reg == oit_pkg::ST_SCAN) && pipe_vld_reg && mt.hit;
    assign scan_end   = (state_reg == oit_pkg::ST_SCAN) && pipe_vld_reg && !mt.hit && pipe_last;
    assign clr_hit    = (state_reg == oit_pkg::ST_CLEAR) && pipe_vld_reg
                        && valid_reg[pipe_idx_reg];
    assign clr_done   = clr_hit && out_free && rest_empty;

    // QoS above 2 is stored as 2; phase kept only at QoS 2
    always_comb
    begin
        req_ent = in_req.ent;
        if (in_req.ent.qos > oit_pkg::QOS_MAX)
        begin
            req_ent.qos = oit_pkg::QOS_MAX;
        end
        req_ent.phase = (req_ent.qos == oit_pkg::QOS_MAX) ? in_req.ent.phase : 1'b0;
    end

    oit_match u_match (
        .key        (cmp_key),
        .slot_id    (rd_ent.id),
        .slot_valid (valid_reg[pipe_idx_reg]),
        .res        (mt)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            oit_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_req.cmd)
                        oit_pkg::CMD_INSERT:
                        begin
                            state_next = ((in_req.ent.id == '0) || full) ?
                                         oit_pkg::ST_RESP : oit_pkg::ST_SCAN;
                        end
                        oit_pkg::CMD_REMOVE, oit_pkg::CMD_LOOKUP, oit_pkg::CMD_ALLOC:
                        begin
                            state_next = oit_pkg::ST_SCAN;
                        end
                        oit_pkg::CMD_CLEAR:
                        begin
                            state_next = (count_reg == '0) ? oit_pkg::ST_RESP
                                                           : oit_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = oit_pkg::ST_RESP;
                        end
                    endcase
                end
            end
            oit_pkg::ST_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = (cmd_reg == oit_pkg::CMD_ALLOC) ? oit_pkg::ST_SCAN
                                                                 : oit_pkg::ST_RESP;
                end
                else if (scan_end)
                begin
                    state_next = (cmd_reg == oit_pkg::CMD_INSERT) ? oit_pkg::ST_WRITE
                                                                  : oit_pkg::ST_RESP;
                end
            end
            oit_pkg::ST_WRITE:
            begin
                state_next = oit_pkg::ST_RESP;
            end
            oit_pkg::ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = oit_pkg::ST_IDLE;
                end
            end
            oit_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = oit_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = oit_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and output register
    always_comb
    begin
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        in_ent_next     = in_ent_reg;
        next_id_next    = next_id_reg;
        cand_next       = cand_reg;
        iss_cnt_next    = iss_cnt_reg;
        pipe_vld_next   = 1'b0;
        pipe_idx_next   = pipe_idx_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        ok_next         = ok_reg;
        ent_next        = ent_reg;
        load_out        = 1'b0;
        load_val        = '0;

        if (issue)
        begin
            iss_cnt_next  = iss_cnt_reg + CNT_W'(1);
            pipe_vld_next = 1'b1;
            pipe_idx_next = ram_raddr;
        end

        case (state_reg)
            oit_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next        = in_req.cmd;
                    key_next        = in_req.ent.id;
                    in_ent_next     = req_ent;
                    ok_next         = 1'b0;
                    ent_next        = '0;
                    iss_cnt_next    = '0;
                    free_found_next = 1'b0;
                    case (in_req.cmd)
                        oit_pkg::CMD_ALLOC:
                        begin
                            cand_next    = nid_fix;
                            next_id_next = nid_fix + oit_pkg::ID_FIRST;
                        end
                        oit_pkg::CMD_CLEAR:
                        begin
                            ok_next = (count_reg == '0);
                        end
                        oit_pkg::CMD_RESET_ID:
                        begin
                            next_id_next = oit_pkg::ID_FIRST;
                            ok_next      = 1'b1;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            oit_pkg::ST_SCAN:
            begin
                if (pipe_vld_reg && mt.free && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = pipe_idx_reg;
                end
                if (scan_hit)
                begin
                    pipe_vld_next = 1'b0;
                    case (cmd_reg)
                        oit_pkg::CMD_ALLOC:
                        begin
                            // id in use: take the next candidate and sweep again
                            cand_next    = nid_fix;
                            next_id_next = nid_fix + oit_pkg::ID_FIRST;
                            iss_cnt_next = '0;
                        end
                        oit_pkg::CMD_REMOVE:
                        begin
                            ok_next                  = 1'b1;
                            ent_next                 = rd_ent;
                            valid_next[pipe_idx_reg] = 1'b0;
                            count_next               = count_reg - CNT_W'(1);
                        end
                        oit_pkg::CMD_LOOKUP:
                        begin
                            ok_next  = 1'b1;
                            ent_next = rd_ent;
                        end
                        default:
                        begin
                            ok_next  = 1'b0;
                            ent_next = '0;
                        end
                    endcase
                end
                else if (scan_end && (cmd_reg == oit_pkg::CMD_ALLOC))
                begin
                    ok_next     = 1'b1;
                    ent_next    = '0;
                    ent_next.id = cand_reg;
                end
            end
            oit_pkg::ST_WRITE:
            begin
                valid_next[free_idx_reg] = 1'b1;
                count_next               = count_reg + CNT_W'(1);
                ok_next                  = 1'b1;
                ent_next                 = in_ent_reg;
            end
            oit_pkg::ST_CLEAR:
            begin
                if (clr_hit)
                begin
                    if (out_free)
                    begin
                        load_out                 = 1'b1;
                        load_val.ok              = 1'b1;
                        load_val.ent             = rd_ent;
                        load_val.last            = rest_empty;
                        valid_next[pipe_idx_reg] = 1'b0;
                        count_next               = count_reg - CNT_W'(1);
                        if (rest_empty)
                        begin
                            pipe_vld_next = 1'b0;
                        end
                    end
                    else
                    begin
                        // output busy: re-read this slot
                        iss_cnt_next  = CNT_W'(pipe_idx_reg);
                        pipe_vld_next = 1'b0;
                    end
                end
            end
            oit_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    load_out       = 1'b1;
                    load_val.ok    = ok_reg;
                    load_val.ent   = ent_reg;
                    load_val.count = oit_pkg::CNT_OUT_W'(count_reg);
                    load_val.full  = full;
                    load_val.last  = 1'b1;
                end
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase

        out_next     = load_out ? load_val : out_reg;
        out_vld_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= oit_pkg::ST_IDLE;
            next_id_reg    <= oit_pkg::ID_FIRST;
            iss_cnt_reg    <= '0;
            pipe_vld_reg   <= 1'b0;
            valid_reg      <= '0;
            count_reg      <= '0;
            free_found_reg <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            next_id_reg    <= next_id_next;
            iss_cnt_reg    <= iss_cnt_next;
            pipe_vld_reg   <= pipe_vld_next;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            free_found_reg <= free_found_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        in_ent_reg   <= in_ent_next;
        cand_reg     <= cand_next;
        pipe_idx_reg <= pipe_idx_next;
        free_idx_reg <= free_idx_next;
        ok_reg       <= ok_next;
        ent_reg      <= ent_next;
        out_reg      <= out_next;
    end

    assign out_valid = out_vld_reg;
    assign out_res   = out_reg;

    `OIT_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH))
    `OIT_ASSERT_IMP(a_count_matches, clk, rst_n, 1'b1, $countones(valid_reg) == count_reg)
    `OIT_ASSERT_IMP(a_no_overwrite, clk, rst_n, load_out, !out_vld_reg || out_ready)
    `OIT_ASSERT_NXT(a_zero_id_reject, clk, rst_n, in_fire && (in_req.cmd == oit_pkg::CMD_INSERT) && (in_req.ent.id == '0), state_reg == oit_pkg::ST_RESP)

endmodule

`default_nettype wire

// ===== src/outbound_inflight_id_table_top.sv =====
// Outbound in-flight id table: TABLE_DEPTH slots in one RAM with a single read
// port, swept one slot per cycle through a shared compare unit while no output
// stall holds a clear; insert adds a write step after the sweep. Allocate
// repeats the sweep for each candidate id already in use, so it takes up to
// (TABLE_DEPTH + 1) sweeps. Clear gives one item per occupied slot in slot
// order; a stall on the output makes the sweep re-read the stalled slot. Slot
// valid bits live in flip-flops, so there is no clearing pass.
// ---------------------------------------------------------------------------
// outbound_inflight_id_table_top
// In-flight packet id table with insert, remove, lookup, allocate, clear and id reset.
// ---------------------------------------------------------------------------
`default_nettype none

module outbound_inflight_id_table_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // pkt_id, message_handle, topic_handle, qos_req, retain_in, phase_in
    input  wire logic [oit_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // cmd
    input  wire logic [oit_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // id_out, message_out, topic_out, qos_out, retain_out, phase_out,
    // occupied_count, full_res
    output logic      [oit_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // ok
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    oit_pkg::req_t                 req;
    oit_pkg::res_t                 res;
    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    logic [IDX_W-1:0]              ram_raddr;
    logic [oit_pkg::ENTRY_W-1:0]   ram_wdata;
    logic [oit_pkg::ENTRY_W-1:0]   ram_rdata;

    always_comb
    begin
        req.cmd        = oit_pkg::cmd_t'(s_axis_tuser);
        req.ent.id     = s_axis_tdata[15:0];
        req.ent.message = s_axis_tdata[31:16];
        req.ent.topic  = s_axis_tdata[47:32];
        req.ent.qos    = s_axis_tdata[49:48];
        req.ent.retain = s_axis_tdata[50];
        req.ent.phase  = s_axis_tdata[51];
    end

    oit_ram #(
        .WIDTH (oit_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    oit_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_req    (req),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    assign m_axis_tdata = {6'b0, res.full, res.count, res.ent.phase, res.ent.retain,
                           res.ent.qos, res.ent.topic, res.ent.message, res.ent.id};
    assign m_axis_tuser = res.ok;
    assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
